[design/ltdl_pkg.sv]
// ============================================================================
// ltdl_pkg: shared types and helpers for the linear TD(lambda) update core
// Holds the cell command codes, the cell control bundle, the register
// indexes with their reset values and the 32-bit saturation helpers.
// ============================================================================
package ltdl_pkg;

  // Default feature count of the core.
  localparam int NUM_FEATURES_DEF = 6;

  // Feature fields carried in one input request.
  localparam int IN_FEATURES = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_DISCOUNT       = 3'd0;
  localparam logic [2:0] REG_TRACE_DECAY    = 3'd1;
  localparam logic [2:0] REG_PLAIN_RATE     = 3'd2;
  localparam logic [2:0] REG_TRACE_RATE     = 3'd3;
  localparam logic [2:0] REG_USE_TRACES     = 3'd4;
  localparam logic [2:0] REG_REPLACE_TRACES = 3'd5;

  // Register reset values.
  localparam logic [15:0] DISCOUNT_RST    = 16'd58982;
  localparam logic [15:0] TRACE_DECAY_RST = 16'd58982;
  localparam logic [15:0] PLAIN_RATE_RST  = 16'd6554;
  localparam logic [15:0] TRACE_RATE_RST  = 16'd6554;

  // Saturation bounds of a signed 32-bit value.
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Commands that the sequencer broadcasts to every cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DOT,
    OP_TMUL,
    OP_TUPD,
    OP_WMUL,
    OP_WUPD,
    OP_ADVANCE
  } cell_op_t;

  // Control bundle shared by the whole row of cells.
  typedef struct packed {
    cell_op_t           op;
    logic               use_traces;
    logic               replace_traces;
    logic [15:0]        ld;
    logic signed [31:0] step;
  } cell_ctl_t;

  // True when a value does not fit a signed 32-bit word.
  function automatic logic sat_ovf(input logic signed [63:0] x);
    return (x > S32_MAX) || (x < S32_MIN);
  endfunction

  // Clamp a value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    priority if (x > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[design/ltdl_cell.sv]
// ============================================================================
// ltdl_cell: one feature slot of the value learner
// Keeps one weight, one trace and the current and next feature. Forms the
// two dot-product terms and adds them into partial sums that move one cell
// down the row every cycle, and performs the local trace and weight updates.
// ============================================================================
module ltdl_cell #(
  parameter int ACC_W = 52
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ltdl_pkg::cell_ctl_t     ctl,
  input  logic signed [15:0]      feat_in,
  input  logic signed [ACC_W-1:0] psum_a_in,
  input  logic signed [ACC_W-1:0] psum_b_in,
  output logic signed [ACC_W-1:0] psum_a_out,
  output logic signed [ACC_W-1:0] psum_b_out,
  output logic                    sat
);
  import ltdl_pkg::*;

  logic signed [31:0] weight;
  logic signed [31:0] trace;
  logic signed [15:0] cur;
  logic signed [15:0] nxt;
  logic signed [48:0] p1;
  logic signed [63:0] p2;
  logic signed [31:0] m1_a;
  logic signed [16:0] m1_b;
  logic signed [31:0] m2_a;
  logic signed [31:0] m2_b;
  logic signed [19:0] f16;
  logic signed [63:0] trace_sum;
  logic signed [63:0] weight_sum;

  // Operand selection for the two multipliers of the cell.
  always_comb begin
    m1_a = weight;
    m1_b = 17'(nxt);
    m2_a = weight;
    m2_b = 32'(cur);
    unique case (ctl.op)
      OP_TMUL: begin
        m1_a = trace;
        m1_b = {1'b0, ctl.ld};
      end
      OP_WMUL: begin
        m2_a = ctl.step;
        m2_b = ctl.use_traces ? trace : 32'(cur);
      end
      default: begin
      end
    endcase
  end

  // Current feature in Q4.16 and the rounded update sums.
  assign f16       = {cur, 4'b0000};
  assign trace_sum = ((64'(p1) + 64'sd32768) >>> 16) + 64'(f16);

  always_comb begin
    if (ctl.use_traces) begin
      weight_sum = ((p2 + 64'sd32768) >>> 16) + 64'(weight);
    end else begin
      weight_sum = ((p2 + 64'sd2048) >>> 12) + 64'(weight);
    end
  end

  // Registered products and the partial sums handed to the next cell.
  always_ff @(posedge clk) begin
    p1         <= m1_a * m1_b;
    p2         <= m2_a * m2_b;
    psum_a_out <= psum_a_in + ACC_W'(p1);
    psum_b_out <= psum_b_in + ACC_W'(p2);
  end

  // Feature, trace and weight state of this slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      trace  <= '0;
      cur    <= '0;
      sat    <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_LOAD: begin
          nxt <= feat_in;
          sat <= 1'b0;
        end
        OP_TUPD: begin
          if (ctl.replace_traces) begin
            trace <= 32'(f16);
          end else begin
            trace <= sat32(trace_sum);
            if (sat_ovf(trace_sum)) sat <= 1'b1;
          end
        end
        OP_WUPD: begin
          weight <= sat32(weight_sum);
          if (sat_ovf(weight_sum)) sat <= 1'b1;
        end
        OP_ADVANCE: begin
          cur <= nxt;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/linear_td_lambda_update_core.sv]
// ============================================================================
// linear_td_lambda_update_core: linear TD(lambda) value learner
// Row of feature cells with a sequencer that forms the TD error, the trace
// decay and the step size, and broadcasts commands to the row.
// ============================================================================
// One request carries the next feature vector and a reward; one result
// carries the TD error, the value of the next features and a saturation
// flag. The partial-sum wave through the row of cells forms both dot
// products at once; the other steps of an update are those of the single
// shared multiplier that scales by gamma and the learning rate, and the
// multiply and update steps inside the cells. A prime request skips them.
// A result waits in the output register while the next request is already
// taken in.
module linear_td_lambda_update_core #(
  parameter int NUM_FEATURES = ltdl_pkg::NUM_FEATURES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, from bit 0: reward, next_pos_x, next_pos_y, next_pos_z,
  // next_dir_x, next_dir_y, next_dir_z (16 bits each).
  input  logic [111:0] s_tdata,
  // s_tuser: prime.
  input  logic [0:0]   s_tuser,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, from bit 0: td_error, next_value (32 bits each).
  output logic [63:0]  m_tdata,
  // m_tuser: saturated.
  output logic [0:0]   m_tuser,
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import ltdl_pkg::*;

  localparam int ACC_W = 49 + $clog2(NUM_FEATURES);
  localparam int VW    = ACC_W - 12;
  localparam int GR_W  = VW + 2;
  localparam int CNT_W = $clog2(NUM_FEATURES + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PROD  = 13'b0000000000010,
    S_SUM   = 13'b0000000000100,
    S_VAL   = 13'b0000000001000,
    S_GLO   = 13'b0000000010000,
    S_GHI   = 13'b0000000100000,
    S_GSUM  = 13'b0000001000000,
    S_DELTA = 13'b0000010000000,
    S_STEP  = 13'b0000100000000,
    S_TRACE = 13'b0001000000000,
    S_WMUL  = 13'b0010000000000,
    S_WUPD  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;

  logic [15:0]        discount;
  logic [15:0]        trace_decay;
  logic [15:0]        plain_rate;
  logic [15:0]        trace_rate;
  logic               use_traces;
  logic               replace_traces;

  logic               prime_q;
  logic signed [15:0] reward_q;
  logic signed [VW-1:0] vnext;
  logic signed [VW-1:0] vcur;
  logic [15:0]        ld;
  logic [40:0]        lo_prod;
  logic signed [GR_W-1:0] gvr;
  logic signed [31:0] delta;
  logic               delta_sat;
  logic signed [31:0] step;

  logic signed [32:0] tm_a;
  logic signed [16:0] tm_b;
  logic signed [49:0] tprod;
  logic signed [63:0] gv_sum;
  logic signed [63:0] delta_full;
  logic signed [49:0] ld_rnd;
  logic signed [49:0] step_rnd;

  logic signed [31:0] td_error_q;
  logic signed [31:0] next_value_q;
  logic               saturated_q;

  logic               s_accept;
  logic               out_free;
  cell_ctl_t          cell_ctl;
  logic [NUM_FEATURES-1:0] cell_sat;
  logic signed [ACC_W-1:0] psum_a [NUM_FEATURES+1];
  logic signed [ACC_W-1:0] psum_b [NUM_FEATURES+1];

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {next_value_q, td_error_q};
  assign m_tuser   = saturated_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      discount       <= DISCOUNT_RST;
      trace_decay    <= TRACE_DECAY_RST;
      plain_rate     <= PLAIN_RATE_RST;
      trace_rate     <= TRACE_RATE_RST;
      use_traces     <= 1'b1;
      replace_traces <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DISCOUNT:       discount       <= cfg_data;
        REG_TRACE_DECAY:    trace_decay    <= cfg_data;
        REG_PLAIN_RATE:     plain_rate     <= cfg_data;
        REG_TRACE_RATE:     trace_rate     <= cfg_data;
        REG_USE_TRACES:     use_traces     <= cfg_data[0];
        REG_REPLACE_TRACES: replace_traces <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state transitions.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_accept) state_next = S_PROD;
      S_PROD:  state_next = S_SUM;
      S_SUM:   if (cnt == CNT_W'(NUM_FEATURES - 1)) state_next = S_VAL;
      S_VAL:   state_next = prime_q ? S_DONE : S_GLO;
      S_GLO:   state_next = S_GHI;
      S_GHI:   state_next = S_GSUM;
      S_GSUM:  state_next = S_DELTA;
      S_DELTA: state_next = S_STEP;
      S_STEP:  state_next = S_TRACE;
      S_TRACE: state_next = S_WMUL;
      S_WMUL:  state_next = S_WUPD;
      S_WUPD:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SUM) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Command broadcast to the row of cells.
  always_comb begin
    cell_ctl.use_traces     = use_traces;
    cell_ctl.replace_traces = replace_traces;
    cell_ctl.ld             = ld;
    cell_ctl.step           = step;
    unique case (state)
      S_IDLE:  cell_ctl.op = s_accept ? OP_LOAD : OP_HOLD;
      S_PROD:  cell_ctl.op = OP_DOT;
      S_SUM:   cell_ctl.op = OP_DOT;
      S_STEP:  cell_ctl.op = OP_TMUL;
      S_TRACE: cell_ctl.op = use_traces ? OP_TUPD : OP_HOLD;
      S_WMUL:  cell_ctl.op = OP_WMUL;
      S_WUPD:  cell_ctl.op = OP_WUPD;
      S_DONE:  cell_ctl.op = out_free ? OP_ADVANCE : OP_HOLD;
      default: cell_ctl.op = OP_HOLD;
    endcase
  end

  // Row of cells; both partial sums enter the first cell at zero.
  assign psum_a[0] = '0;
  assign psum_b[0] = '0;

  for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_cell
    logic signed [15:0] feat;
    if (i < IN_FEATURES) begin : g_in
      assign feat = s_tdata[16*(i+1) +: 16];
    end else begin : g_zero
      assign feat = '0;
    end
    ltdl_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .feat_in    (feat),
      .psum_a_in  (psum_a[i]),
      .psum_b_in  (psum_b[i]),
      .psum_a_out (psum_a[i+1]),
      .psum_b_out (psum_b[i+1]),
      .sat        (cell_sat[i])
    );
  end

  // Shared multiplier: lambda*gamma by default, then gamma*Vnext in two
  // halves, then the learning rate times delta.
  always_comb begin
    tm_a = $signed({17'b0, trace_decay});
    tm_b = $signed({1'b0, discount});
    unique case (state)
      S_GLO:  tm_a = $signed({9'b0, vnext[23:0]});
      S_GHI:  tm_a = 33'(vnext >>> 24);
      S_STEP: begin
        tm_a = 33'(delta);
        tm_b = $signed({1'b0, use_traces ? trace_rate : plain_rate});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tprod <= tm_a * tm_b;
  end

  // Rounded scalar terms of lambda*gamma, the TD error and the step size.
  assign ld_rnd     = tprod + 50'sd32768;
  assign step_rnd   = (tprod + 50'sd32768) >>> 16;
  assign gv_sum     = (64'(tprod) <<< 24) + $signed({23'b0, lo_prod}) + 64'sd32768;
  assign delta_full = (64'(reward_q) <<< 8) + 64'(gvr) - 64'(vcur);

  // Scalar datapath registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      prime_q  <= s_tuser[0];
      reward_q <= s_tdata[15:0];
    end
    unique case (state)
      S_VAL: begin
        vnext <= VW'((psum_a[NUM_FEATURES] + ACC_W'(2048)) >>> 12);
        vcur  <= VW'((psum_b[NUM_FEATURES] + ACC_W'(2048)) >>> 12);
        ld    <= ld_rnd[31:16];
      end
      S_GHI:   lo_prod <= tprod[40:0];
      S_GSUM:  gvr     <= GR_W'(gv_sum >>> 16);
      S_DELTA: begin
        delta     <= sat32(delta_full);
        delta_sat <= sat_ovf(delta_full);
      end
      S_TRACE: step <= step_rnd[31:0];
      default: begin
      end
    endcase
  end

  // Output register; a prime request reports no error and no saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if ((state == S_DONE) && out_free) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      next_value_q <= sat32(64'(vnext));
      if (prime_q) begin
        td_error_q  <= '0;
        saturated_q <= 1'b0;
      end else begin
        td_error_q  <= delta;
        saturated_q <= delta_sat || (|cell_sat);
      end
    end
  end

endmodule
